// File: rtl/tsel_pkg.sv
`default_nettype none

package tsel_pkg;

	localparam int POP_SIZE  = 64;
	localparam int FIT_WIDTH = 32;
	localparam int SLOT_W    = $clog2(POP_SIZE);
	localparam int GRP_W     = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOK_FOR_MAX = 2'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	localparam logic [GRP_W-1:0] GROUP_RESET = 6'd2;
	localparam logic [GRP_W-1:0] GROUP_MAX   = GRP_W'(POP_SIZE - 1);

	typedef struct packed {
		logic                        operation;
		logic [5:0]                  slot;
		logic signed [FIT_WIDTH-1:0] fitness;
	} item_t;

	typedef struct packed {
		logic [5:0]                  winner_slot;
		logic signed [FIT_WIDTH-1:0] winner_fitness;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/tournament_selection.sv
// Datapath: a draw item is captured in the table read register and the stage-1 registers,
// then, if it ends the group, its winner is registered into result with done high.
// Throughput: one item per cycle, load or draw; busy stays low, bound by one table read
// and one signed compare against the running best per cycle.
// Reset clears the running best, the draw count and the registers (group size 2, min);
// the fitness table is not cleared and holds garbage until each slot is loaded.
`default_nettype none

module tournament_selection
	import tsel_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire item_t                item,
	output logic                      done,
	output result_t                   result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	logic                  accept;
	logic [GRP_W-1:0]      group_q;
	logic                  look_max_q;
	logic                  valid_s1;
	logic                  op_s1;
	logic [SLOT_W-1:0]     slot_s1;
	logic [FIT_WIDTH-1:0]  rd_fit;
	logic [SLOT_W-1:0]     best_slot_q;
	logic [FIT_WIDTH-1:0]  best_fit_q;
	logic [GRP_W-1:0]      draws_q;
	logic                  take;
	logic [SLOT_W-1:0]     nxt_slot;
	logic [FIT_WIDTH-1:0]  nxt_fit;
	logic [GRP_W:0]        draws_inc;
	logic [GRP_W-1:0]      eff_group;
	logic                  group_end;
	logic                  draw_s1;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q    <= GROUP_RESET;
			look_max_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GROUP_SIZE:   group_q    <= cfg_data[GRP_W-1:0];
				CFG_LOOK_FOR_MAX: look_max_q <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Loads write at the accept edge, so a draw right behind a load reads the new value.
	tsel_ram #(
		.WIDTH (FIT_WIDTH),
		.DEPTH (POP_SIZE)
	) u_table (
		.clk   (clk),
		.we    (accept && item.operation == OP_LOAD),
		.waddr (item.slot[SLOT_W-1:0]),
		.wdata (item.fitness),
		.re    (accept && item.operation == OP_DRAW),
		.raddr (item.slot[SLOT_W-1:0]),
		.rdata (rd_fit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= item.operation;
			slot_s1 <= item.slot[SLOT_W-1:0];
		end
	end

	assign draw_s1 = valid_s1 && op_s1 == OP_DRAW;

	always_comb begin
		if (draws_q == '0) begin
			take = 1'b1;
		end else if (look_max_q) begin
			take = $signed(best_fit_q) < $signed(rd_fit);
		end else begin
			take = $signed(rd_fit) < $signed(best_fit_q);
		end
		nxt_slot  = take ? slot_s1 : best_slot_q;
		nxt_fit   = take ? rd_fit : best_fit_q;
		draws_inc = {1'b0, draws_q} + (GRP_W+1)'(1);
		if (group_q == '0) begin
			eff_group = GRP_W'(1);
		end else if (group_q > GROUP_MAX) begin
			eff_group = GROUP_MAX;
		end else begin
			eff_group = group_q;
		end
		// count wraps in the low bits like the running counter does
		group_end = draws_inc[GRP_W-1:0] >= eff_group;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_slot_q <= '0;
			best_fit_q  <= '0;
			draws_q     <= '0;
			done        <= 1'b0;
		end else begin
			done <= draw_s1 && group_end;
			if (draw_s1) begin
				best_slot_q <= nxt_slot;
				best_fit_q  <= nxt_fit;
				draws_q     <= group_end ? '0 : draws_inc[GRP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (draw_s1 && group_end) begin
			result.winner_slot    <= 6'(nxt_slot);
			result.winner_fitness <= nxt_fit;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tsel_ram.sv
`default_nettype none

module tsel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
